// ===== rtl/tnpf_pkg.sv =====
package tnpf_pkg;

	localparam int MAX_POINTS = 64;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int COORD_W    = 16;
	localparam int CODE_W     = 8;
	localparam int ID_W       = 16;
	localparam int MAG_W      = COORD_W;
	localparam int SQ_W       = 2 * MAG_W;
	localparam int RAD_W      = SQ_W + 1;

	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	localparam logic KIND_PAIR = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic [CODE_W-1:0]         code;
		logic [ID_W-1:0]           id;
	} point_t;

	localparam int POINT_W = $bits(point_t);

	// controller to datapath
	typedef struct packed {
		logic load_point;
		logic clear_count;
		logic issue_read;
		logic end_load;
		logic store_ok;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic adv;
		logic count_zero;
		logic count_full;
		logic scan_last;
		logic pipe_busy;
	} dp_stat_t;

endpackage

// ===== rtl/tnpf_ram.sv =====
module tnpf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/tnpf_ctrl.sv =====
module tnpf_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               cmd,
	output logic               in_ready,
	input  tnpf_pkg::dp_stat_t stat,
	output tnpf_pkg::dp_cmd_t  dcmd
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_DRAIN  = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic   store_q, store_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		store_d = store_q;
		dcmd    = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					if (cmd == tnpf_pkg::CMD_CLEAR) begin
						dcmd.clear_count = 1'b1;
					end else begin
						dcmd.load_point = 1'b1;
						store_d         = !stat.count_full;
						if (stat.count_full || stat.count_zero) begin
							state_d = ST_FINISH;
						end else begin
							state_d = ST_SCAN;
						end
					end
				end
			end
			ST_SCAN: begin
				if (stat.adv) begin
					dcmd.issue_read = 1'b1;
					if (stat.scan_last) begin
						state_d = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				if (!stat.pipe_busy) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (stat.adv) begin
					dcmd.end_load = 1'b1;
					dcmd.store_ok = store_q;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			store_q <= 1'b0;
		end else begin
			state_q <= state_d;
			store_q <= store_d;
		end
	end

endmodule

// ===== rtl/tnpf_datapath.sv =====
module tnpf_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic [tnpf_pkg::RAD_W-1:0]           radius_squared,
	input  logic signed [tnpf_pkg::COORD_W-1:0]  pos_x,
	input  logic signed [tnpf_pkg::COORD_W-1:0]  pos_y,
	input  logic [tnpf_pkg::CODE_W-1:0]          feature_code,
	input  logic [tnpf_pkg::ID_W-1:0]            point_id,
	input  tnpf_pkg::dp_cmd_t                    dcmd,
	output tnpf_pkg::dp_stat_t                   stat,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 kind,
	output logic [tnpf_pkg::ID_W-1:0]            a_id,
	output logic [tnpf_pkg::CODE_W-1:0]          a_code,
	output logic signed [tnpf_pkg::COORD_W-1:0]  a_x,
	output logic signed [tnpf_pkg::COORD_W-1:0]  a_y,
	output logic [tnpf_pkg::ID_W-1:0]            b_id,
	output logic [tnpf_pkg::CODE_W-1:0]          b_code,
	output logic signed [tnpf_pkg::COORD_W-1:0]  b_x,
	output logic signed [tnpf_pkg::COORD_W-1:0]  b_y,
	output logic                                 was_stored,
	output logic                                 last
);

	logic [tnpf_pkg::RAD_W-1:0] radius_q;
	logic [tnpf_pkg::CNT_W-1:0] count_q;
	logic [tnpf_pkg::IDX_W-1:0] addr_q;
	tnpf_pkg::point_t           np_q;
	tnpf_pkg::point_t           rd_point;
	logic [tnpf_pkg::POINT_W-1:0] rd_data;
	logic                       adv;

	// pipeline
	logic                       v_s1, v_s2, v_s3;
	logic [tnpf_pkg::MAG_W-1:0] adx_s2, ady_s2;
	logic                       neq_s2, lo_s2;
	tnpf_pkg::point_t           ent_s2;
	logic [tnpf_pkg::SQ_W-1:0]  sqx_s3, sqy_s3;
	logic                       neq_s3, lo_s3;
	tnpf_pkg::point_t           ent_s3;

	logic signed [tnpf_pkg::COORD_W:0] dx, dy;
	logic [tnpf_pkg::COORD_W:0]        dx_neg, dy_neg;
	logic [tnpf_pkg::MAG_W-1:0]        adx, ady;
	logic [tnpf_pkg::RAD_W-1:0]        d2;
	logic                              hit;
	logic [tnpf_pkg::CNT_W-1:0]        count_m1;

	logic out_valid_q;
	tnpf_pkg::point_t a_q, b_q;
	logic kind_q, stored_q, last_q;

	assign adv      = !out_valid_q || out_ready;
	assign count_m1 = count_q - tnpf_pkg::CNT_W'(1);

	assign stat.adv        = adv;
	assign stat.count_zero = (count_q == '0);
	assign stat.count_full = (count_q == tnpf_pkg::CNT_W'(tnpf_pkg::MAX_POINTS));
	assign stat.scan_last  = ({1'b0, addr_q} == count_m1);
	assign stat.pipe_busy  = v_s1 || v_s2 || v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= '0;
		end else if (cfg_valid) begin
			radius_q <= radius_squared;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (dcmd.clear_count) begin
			count_q <= '0;
		end else if (dcmd.store_ok) begin
			count_q <= count_q + tnpf_pkg::CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.load_point) begin
			np_q.x    <= pos_x;
			np_q.y    <= pos_y;
			np_q.code <= feature_code;
			np_q.id   <= point_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q <= '0;
		end else if (dcmd.load_point) begin
			addr_q <= '0;
		end else if (dcmd.issue_read) begin
			addr_q <= addr_q + tnpf_pkg::IDX_W'(1);
		end
	end

	tnpf_ram #(
		.WIDTH(tnpf_pkg::POINT_W),
		.DEPTH(tnpf_pkg::MAX_POINTS)
	) u_store (
		.clk    (clk),
		.wr_en  (dcmd.store_ok),
		.wr_addr(count_q[tnpf_pkg::IDX_W-1:0]),
		.wr_data(np_q),
		.rd_en  (dcmd.issue_read),
		.rd_addr(addr_q),
		.rd_data(rd_data)
	);

	assign rd_point = rd_data;

	// absolute coordinate differences
	assign dx     = {np_q.x[tnpf_pkg::COORD_W-1], np_q.x} -
	                {rd_point.x[tnpf_pkg::COORD_W-1], rd_point.x};
	assign dy     = {np_q.y[tnpf_pkg::COORD_W-1], np_q.y} -
	                {rd_point.y[tnpf_pkg::COORD_W-1], rd_point.y};
	assign dx_neg = -dx;
	assign dy_neg = -dy;
	assign adx    = dx[tnpf_pkg::COORD_W] ? dx_neg[tnpf_pkg::MAG_W-1:0] : dx[tnpf_pkg::MAG_W-1:0];
	assign ady    = dy[tnpf_pkg::COORD_W] ? dy_neg[tnpf_pkg::MAG_W-1:0] : dy[tnpf_pkg::MAG_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= dcmd.issue_read;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			adx_s2 <= adx;
			ady_s2 <= ady;
			neq_s2 <= (np_q.code != rd_point.code);
			lo_s2  <= (np_q.code < rd_point.code);
			ent_s2 <= rd_point;
			sqx_s3 <= adx_s2 * adx_s2;
			sqy_s3 <= ady_s2 * ady_s2;
			neq_s3 <= neq_s2;
			lo_s3  <= lo_s2;
			ent_s3 <= ent_s2;
		end
	end

	assign d2  = {1'b0, sqx_s3} + {1'b0, sqy_s3};
	assign hit = v_s3 && neq_s3 && (d2 <= radius_q);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dcmd.end_load || hit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (dcmd.end_load) begin
				kind_q   <= tnpf_pkg::KIND_END;
				a_q      <= '0;
				b_q      <= '0;
				stored_q <= dcmd.store_ok;
				last_q   <= 1'b1;
			end else if (hit) begin
				kind_q   <= tnpf_pkg::KIND_PAIR;
				a_q      <= lo_s3 ? np_q : ent_s3;
				b_q      <= lo_s3 ? ent_s3 : np_q;
				stored_q <= 1'b0;
				last_q   <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign a_id       = a_q.id;
	assign a_code     = a_q.code;
	assign a_x        = a_q.x;
	assign a_y        = a_q.y;
	assign b_id       = b_q.id;
	assign b_code     = b_q.code;
	assign b_x        = b_q.x;
	assign b_y        = b_q.y;
	assign was_stored = stored_q;
	assign last       = last_q;

endmodule

// ===== rtl/typed_neighbor_pair_finder.sv =====
// an added point is compared with each stored point, one store read per cycle while the
// output is not stalled, through a 3-stage distance pipeline; the controller then waits
// for the pipeline to drain and loads the end word (an empty or full store skips the scan)
// the next input word is taken only once the end word of an add is loaded; a clear
// leaves the block ready for the next word; output stalls hold up the scan and end word
// reset: arst_n clears point count, radius_squared and control; store is never read unwritten
module typed_neighbor_pair_finder (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tnpf_pkg::RAD_W-1:0]          radius_squared,
	// input word channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                cmd,
	input  logic signed [tnpf_pkg::COORD_W-1:0] pos_x,
	input  logic signed [tnpf_pkg::COORD_W-1:0] pos_y,
	input  logic [tnpf_pkg::CODE_W-1:0]         feature_code,
	input  logic [tnpf_pkg::ID_W-1:0]           point_id,
	// result word channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                kind,
	output logic [tnpf_pkg::ID_W-1:0]           a_id,
	output logic [tnpf_pkg::CODE_W-1:0]         a_code,
	output logic signed [tnpf_pkg::COORD_W-1:0] a_x,
	output logic signed [tnpf_pkg::COORD_W-1:0] a_y,
	output logic [tnpf_pkg::ID_W-1:0]           b_id,
	output logic [tnpf_pkg::CODE_W-1:0]         b_code,
	output logic signed [tnpf_pkg::COORD_W-1:0] b_x,
	output logic signed [tnpf_pkg::COORD_W-1:0] b_y,
	output logic                                was_stored,
	output logic                                last
);

	tnpf_pkg::dp_cmd_t  dcmd;
	tnpf_pkg::dp_stat_t stat;
	logic               in_take;

	// the register can be written any time; it is only to be changed while idle, which the block does not enforce
	assign cfg_ready = 1'b1;

	// controller only sees a word when it can take it
	assign in_take = in_valid && in_ready;

	// controller: take clears and adds; for an add, scan the store, drain the pipeline, emit end word
	tnpf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_take),
		.cmd     (cmd),
		.in_ready(in_ready),
		.stat    (stat),
		.dcmd    (dcmd)
	);

	// datapath: point store, distance pipeline, result word register
	tnpf_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.radius_squared(radius_squared),
		.pos_x         (pos_x),
		.pos_y         (pos_y),
		.feature_code  (feature_code),
		.point_id      (point_id),
		.dcmd          (dcmd),
		.stat          (stat),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.a_id          (a_id),
		.a_code        (a_code),
		.a_x           (a_x),
		.a_y           (a_y),
		.b_id          (b_id),
		.b_code        (b_code),
		.b_x           (b_x),
		.b_y           (b_y),
		.was_stored    (was_stored),
		.last          (last)
	);

endmodule

// ===== rtl/tnpf_checker.sv =====
module tnpf_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                cmd,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic                                kind,
	input logic [tnpf_pkg::ID_W-1:0]           a_id,
	input logic [tnpf_pkg::CODE_W-1:0]         a_code,
	input logic [tnpf_pkg::ID_W-1:0]           b_id,
	input logic [tnpf_pkg::CODE_W-1:0]         b_code,
	input logic                                was_stored,
	input logic                                last
);

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(a_id)
			&& $stable(b_id) && $stable(last))
		else $error("result word changed while stalled");

	// an added point leaves the block busy in the cycle after it is taken
	a_busy_after_add: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (cmd == tnpf_pkg::CMD_ADD) |=> !in_ready)
		else $error("input taken again right after an add");

	// pair words never end a run
	a_pair_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == tnpf_pkg::KIND_PAIR) |-> !last && !was_stored)
		else $error("pair word with end flags");

	// end word is last and carries no members
	a_end_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == tnpf_pkg::KIND_END) |-> last && (a_id == '0) && (b_id == '0))
		else $error("malformed end word");

	// lower code member comes first
	a_pair_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == tnpf_pkg::KIND_PAIR) |-> a_code < b_code)
		else $error("pair members out of order");

endmodule

bind typed_neighbor_pair_finder tnpf_checker u_tnpf_checker (.*);

// ===== dv/tb_top.sv =====
module tb_top;

	localparam int HALF_PERIOD    = 6;
	localparam int RESET_CYCLES   = 8;
	localparam int ITEM_TARGET    = 470;
	// longest quiet stretch is the receiver hold-off, well under this
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 300;
	// full scan of 63 stored points plus the distance pipeline, rounded up
	localparam int LATENCY_PAD    = 70;
	localparam int PLAN_ROWS      = 23;

	// one result word as the block presents it
	typedef struct packed {
		logic             kind;
		tnpf_pkg::point_t a;
		tnpf_pkg::point_t b;
		logic             was_stored;
		logic             last;
	} res_word_t;

	// directed plan: adds, clears, radius writes and one fill to capacity
	typedef enum {ROW_ADD, ROW_CLEAR, ROW_CFG, ROW_FILL} row_op_e;

	typedef struct {
		row_op_e                    op;
		logic [tnpf_pkg::RAD_W-1:0] radius;
		tnpf_pkg::point_t           pt;
		bit                         typed;        // expectation written out by hand
		bit                         typed_stored; // hand-written end word: stored flag
	} plan_row_t;

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                cfg_valid;
	logic                                cfg_ready;
	logic [tnpf_pkg::RAD_W-1:0]          radius_squared;
	logic                                in_valid;
	logic                                in_ready;
	logic                                cmd;
	logic signed [tnpf_pkg::COORD_W-1:0] pos_x;
	logic signed [tnpf_pkg::COORD_W-1:0] pos_y;
	logic [tnpf_pkg::CODE_W-1:0]         feature_code;
	logic [tnpf_pkg::ID_W-1:0]           point_id;
	logic                                out_valid;
	logic                                out_ready;
	logic                                kind;
	logic [tnpf_pkg::ID_W-1:0]           a_id;
	logic [tnpf_pkg::CODE_W-1:0]         a_code;
	logic signed [tnpf_pkg::COORD_W-1:0] a_x;
	logic signed [tnpf_pkg::COORD_W-1:0] a_y;
	logic [tnpf_pkg::ID_W-1:0]           b_id;
	logic [tnpf_pkg::CODE_W-1:0]         b_code;
	logic signed [tnpf_pkg::COORD_W-1:0] b_x;
	logic signed [tnpf_pkg::COORD_W-1:0] b_y;
	logic                                was_stored;
	logic                                last;

	// mirror of the block state
	tnpf_pkg::point_t           held_pts [tnpf_pkg::MAX_POINTS];
	int                         held_count = 0;
	logic [tnpf_pkg::RAD_W-1:0] radius_now = '0;

	// result words still owed by the block, oldest first
	res_word_t owed_words [$];
	int        mismatches = 0;
	int        idle_cycles = 0;
	bit        no_idle = 1'b0;
	bit        hold_req = 1'b0;

	plan_row_t plan [PLAN_ROWS] = '{
		// radius still at its reset value of zero
		'{ROW_ADD,   '0, '{16'sd0, 16'sd0, 8'd5, 16'd1}, 1'b1, 1'b1},
		// same code on the same spot: never a pair
		'{ROW_ADD,   '0, '{16'sd0, 16'sd0, 8'd5, 16'd2}, 1'b1, 1'b1},
		// lower code arrives: new point goes first
		'{ROW_ADD,   '0, '{16'sd0, 16'sd0, 8'd3, 16'd3}, 1'b0, 1'b0},
		// higher code arrives: new point goes second
		'{ROW_ADD,   '0, '{16'sd0, 16'sd0, 8'd9, 16'd4}, 1'b0, 1'b0},
		// one unit away is already outside a zero radius
		'{ROW_ADD,   '0, '{16'sd1, 16'sd0, 8'd0, 16'd5}, 1'b1, 1'b1},
		// clear with every other field at an extreme, all ignored
		'{ROW_CLEAR, '0, '{16'sh7fff, 16'sh8000, 8'hff, 16'hffff}, 1'b0, 1'b0},
		// widest radius: corners of the plane still pair
		'{ROW_CFG,   {tnpf_pkg::RAD_W{1'b1}}, '{16'sd0, 16'sd0, 8'd0, 16'd0}, 1'b0, 1'b0},
		'{ROW_ADD,   '0, '{16'sh8000, 16'sh8000, 8'h00, 16'h0000}, 1'b0, 1'b0},
		'{ROW_ADD,   '0, '{16'sh7fff, 16'sh7fff, 8'hff, 16'hffff}, 1'b0, 1'b0},
		'{ROW_ADD,   '0, '{16'sh7fff, 16'sh8000, 8'h80, 16'h8000}, 1'b0, 1'b0},
		'{ROW_ADD,   '0, '{16'sh8000, 16'sh7fff, 8'hff, 16'h7fff}, 1'b0, 1'b0},
		// one below the full diagonal: only the diagonal pair drops out
		'{ROW_CFG,   33'd8589672449, '{16'sd0, 16'sd0, 8'd0, 16'd0}, 1'b0, 1'b0},
		'{ROW_ADD,   '0, '{16'sh8000, 16'sh8000, 8'h01, 16'h1234}, 1'b0, 1'b0},
		'{ROW_CLEAR, '0, '{16'sd0, 16'sd0, 8'd0, 16'd0}, 1'b0, 1'b0},
		// small radius with distance exactly on the boundary
		'{ROW_CFG,   33'd25, '{16'sd0, 16'sd0, 8'd0, 16'd0}, 1'b0, 1'b0},
		'{ROW_ADD,   '0, '{16'sd3, 16'sd4, 8'd1, 16'd10}, 1'b0, 1'b0},
		'{ROW_ADD,   '0, '{16'sd0, 16'sd0, 8'd2, 16'd11}, 1'b0, 1'b0},
		'{ROW_ADD,   '0, '{-16'sd3, -16'sd4, 8'd2, 16'd12}, 1'b0, 1'b0},
		// fill the store up to capacity
		'{ROW_FILL,  '0, '{16'sd0, 16'sd0, 8'd0, 16'd0}, 1'b0, 1'b0},
		// full store: dropped, no search
		'{ROW_ADD,   '0, '{16'sd0, 16'sd0, 8'd7, 16'd99}, 1'b1, 1'b0},
		'{ROW_ADD,   '0, '{16'sd1, 16'sd1, 8'd8, 16'd100}, 1'b1, 1'b0},
		'{ROW_CLEAR, '0, '{16'sd0, 16'sd0, 8'd0, 16'd0}, 1'b0, 1'b0},
		// empty store again after the clear
		'{ROW_ADD,   '0, '{16'sd5, 16'sd5, 8'd4, 16'd200}, 1'b1, 1'b1}
	};

	typed_neighbor_pair_finder dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.radius_squared (radius_squared),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.cmd            (cmd),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.feature_code   (feature_code),
		.point_id       (point_id),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.kind           (kind),
		.a_id           (a_id),
		.a_code         (a_code),
		.a_x            (a_x),
		.a_y            (a_y),
		.b_id           (b_id),
		.b_code         (b_code),
		.b_x            (b_x),
		.b_y            (b_y),
		.was_stored     (was_stored),
		.last           (last)
	);

	always #HALF_PERIOD clk = ~clk;

	// cycles to wait before the next word on either side
	function automatic int pause_len();
		return no_idle ? 0 : $urandom_range(0, 8);
	endfunction

	function automatic res_word_t end_word(input logic stored);
		res_word_t w;
		w            = '0;
		w.kind       = tnpf_pkg::KIND_END;
		w.was_stored = stored;
		w.last       = 1'b1;
		return w;
	endfunction

	// random point around a center, wrapping at the edges of the plane
	function automatic tnpf_pkg::point_t rand_point(
			input logic [tnpf_pkg::COORD_W-1:0] cx, cy,
			input int spread, input int code_lo, input int code_span);
		tnpf_pkg::point_t p;
		p.x    = tnpf_pkg::COORD_W'(int'(cx) + int'($urandom_range(0, 2 * spread)) - spread);
		p.y    = tnpf_pkg::COORD_W'(int'(cy) + int'($urandom_range(0, 2 * spread)) - spread);
		p.code = tnpf_pkg::CODE_W'(code_lo + int'($urandom_range(0, code_span - 1)));
		p.id   = tnpf_pkg::ID_W'($urandom);
		return p;
	endfunction

	// clear, or search held points for typed neighbors and store if not full
	function automatic void search_and_store(input logic c, input tnpf_pkg::point_t np,
			ref res_word_t found[$]);
		longint    dx;
		longint    dy;
		res_word_t w;
		found.delete();
		if (c == tnpf_pkg::CMD_CLEAR) begin
			held_count = 0;
			return;
		end
		if (held_count < tnpf_pkg::MAX_POINTS) begin
			for (int i = 0; i < held_count; i++) begin
				dx = longint'($signed(np.x)) - longint'($signed(held_pts[i].x));
				dy = longint'($signed(np.y)) - longint'($signed(held_pts[i].y));
				if (held_pts[i].code != np.code &&
						dx * dx + dy * dy <= longint'(radius_now)) begin
					w            = '0;
					w.kind       = tnpf_pkg::KIND_PAIR;
					// lower feature code goes in the a slot
					if (np.code < held_pts[i].code) begin
						w.a = np;
						w.b = held_pts[i];
					end else begin
						w.a = held_pts[i];
						w.b = np;
					end
					found.insert(found.size(), w);
				end
			end
			held_pts[held_count] = np;
			held_count++;
			found.insert(found.size(), end_word(1'b1));
		end else begin
			found.insert(found.size(), end_word(1'b0));
		end
	endfunction

	// offer one input word, hold it until taken, then log what it owes
	task automatic push_word(input logic c, input tnpf_pkg::point_t p, input bit typed,
			input bit typed_stored);
		int        gap;
		res_word_t found [$];
		gap = pause_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		cmd          <= c;
		pos_x        <= p.x;
		pos_y        <= p.y;
		feature_code <= p.code;
		point_id     <= p.id;
		do @(posedge clk); while (!in_ready);
		search_and_store(c, p, found);
		if (typed)
			owed_words.insert(owed_words.size(), end_word(typed_stored));
		else
			foreach (found[i]) owed_words.insert(owed_words.size(), found[i]);
	endtask

	// drain everything owed, then give a trailing clear time to finish
	task automatic settle();
		in_valid <= 1'b0;
		while (owed_words.size() != 0) @(posedge clk);
		repeat (LATENCY_PAD) @(posedge clk);
	endtask

	task automatic write_radius(input logic [tnpf_pkg::RAD_W-1:0] r);
		cfg_valid      <= 1'b1;
		radius_squared <= r;
		do @(posedge clk); while (!cfg_ready);
		radius_now = r;
		cfg_valid <= 1'b0;
	endtask

	function automatic void check_field(input string name, input longint want_v,
			input longint got_v);
		if (want_v != got_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, want_v, got_v);
			mismatches++;
		end
	endfunction

	// stimulus: directed plan first, then random phases
	initial begin
		int                           adds_sent;
		int                           phase;
		int                           len;
		int                           spread;
		int                           code_lo;
		int                           code_span;
		logic [tnpf_pkg::RAD_W-1:0]   r;
		logic [tnpf_pkg::COORD_W-1:0] cx;
		logic [tnpf_pkg::COORD_W-1:0] cy;
		tnpf_pkg::point_t             p;

		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		radius_squared = '0;
		in_valid       = 1'b0;
		cmd            = tnpf_pkg::CMD_ADD;
		pos_x          = '0;
		pos_y          = '0;
		feature_code   = '0;
		point_id       = '0;
		adds_sent      = 0;
		phase          = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			case (plan[i].op)
				ROW_ADD: begin
					push_word(tnpf_pkg::CMD_ADD, plan[i].pt, plan[i].typed,
						plan[i].typed_stored);
					adds_sent++;
				end
				ROW_CLEAR: begin
					push_word(tnpf_pkg::CMD_CLEAR, plan[i].pt, 1'b0, 1'b0);
				end
				ROW_CFG: begin
					settle();
					write_radius(plan[i].radius);
				end
				ROW_FILL: begin
					// tight cluster, few types: plenty of pairs on the way up
					while (held_count < tnpf_pkg::MAX_POINTS) begin
						push_word(tnpf_pkg::CMD_ADD, rand_point('0, '0, 8, 0, 4), 1'b0, 1'b0);
						adds_sent++;
					end
				end
			endcase
		end

		while (adds_sent < ITEM_TARGET) begin
			settle();
			no_idle = ($urandom_range(0, 3) == 0);
			// mostly clusters, now and then the whole plane
			spread  = ($urandom_range(0, 4) == 0) ? 32768 : (1 << $urandom_range(0, 7));
			case ($urandom_range(0, 4))
				0:       r = '0;
				1:       r = {tnpf_pkg::RAD_W{1'b1}};
				2:       r = tnpf_pkg::RAD_W'($urandom_range(0, 2 * spread * spread));
				3:       r = tnpf_pkg::RAD_W'(spread * spread);
				default: r = tnpf_pkg::RAD_W'({$urandom, $urandom});
			endcase
			write_radius(r);
			// block fills up while the receiver sits still
			if (phase == 2 || $urandom_range(0, 9) == 0)
				hold_req = 1'b1;
			cx        = tnpf_pkg::COORD_W'($urandom);
			cy        = tnpf_pkg::COORD_W'($urandom);
			code_lo   = $urandom_range(0, 255);
			code_span = ($urandom_range(0, 4) == 0) ? 256 : $urandom_range(1, 6);
			if ($urandom_range(0, 4) != 0)
				push_word(tnpf_pkg::CMD_CLEAR, rand_point(cx, cy, 32768, 0, 256), 1'b0, 1'b0);
			// some runs go past capacity to hit the drop case
			len = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 75) : $urandom_range(1, 30);
			for (int k = 0; k < len; k++) begin
				if ($urandom_range(0, 19) == 0) begin
					// stray clear in the middle of a run
					push_word(tnpf_pkg::CMD_CLEAR, rand_point(cx, cy, 32768, 0, 256),
						1'b0, 1'b0);
				end else begin
					p = rand_point(cx, cy, spread, code_lo, code_span);
					push_word(tnpf_pkg::CMD_ADD, p, 1'b0, 1'b0);
					adds_sent++;
				end
			end
			phase++;
		end

		settle();
		if (mismatches == 0 && owed_words.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// receiver: random stall per word, plus the long hold-off on request
	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stall = pause_len();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// compare every taken result word with the oldest one owed
	always @(posedge clk) begin
		res_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (owed_words.size() == 0) begin
				$error("result word with nothing owed: kind %0d id %0d", kind, a_id);
				mismatches++;
			end else begin
				want = owed_words.pop_front();
				check_field("kind", want.kind, kind);
				check_field("a_id", want.a.id, a_id);
				check_field("a_code", want.a.code, a_code);
				check_field("a_x", want.a.x, a_x);
				check_field("a_y", want.a.y, a_y);
				check_field("b_id", want.b.id, b_id);
				check_field("b_code", want.b.code, b_code);
				check_field("b_x", want.b.x, b_x);
				check_field("b_y", want.b.y, b_y);
				check_field("was_stored", want.was_stored, was_stored);
				check_field("last", want.last, last);
			end
		end
	end

	// watchdog: too long without any word moving on any channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

// ===== sim.f =====
rtl/tnpf_pkg.sv
rtl/tnpf_ram.sv
rtl/tnpf_ctrl.sv
rtl/tnpf_datapath.sv
rtl/typed_neighbor_pair_finder.sv
rtl/tnpf_checker.sv
dv/tb_top.sv
